### src/assert_macros.svh
// Assertion helpers shared by the RTL. Both take a clock and an active-low
// reset; checks are disabled while reset is asserted.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

### src/stt_pkg.sv
package stt_pkg;

    // Scanner modes.
    typedef enum logic [3:0] {
        MODE_IDLE,
        MODE_SLASH,
        MODE_COMMENT,
        MODE_INT,
        MODE_INTDOT,
        MODE_FLOAT,
        MODE_IDENT,
        MODE_EQ,
        MODE_BANG
    } t_mode;

    // Token kinds as seen on the result port.
    typedef enum logic [4:0] {
        KIND_EOF,
        KIND_INT,
        KIND_FLOAT,
        KIND_IDENT,
        KIND_FUNC,
        KIND_RETURN,
        KIND_IF,
        KIND_ELSE,
        KIND_PLUS,
        KIND_MINUS,
        KIND_STAR,
        KIND_SLASH,
        KIND_LPAREN,
        KIND_RPAREN,
        KIND_LBRACE,
        KIND_RBRACE,
        KIND_COMMA,
        KIND_SEMI,
        KIND_ASSIGN,
        KIND_EQEQ,
        KIND_BANGEQ,
        KIND_ERROR
    } t_kind;

    // Character codes.
    localparam logic [7:0] CH_EOS    = 8'h00;
    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_BANG   = 8'h21;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_EQ     = 8'h3D;
    localparam logic [7:0] CH_UNDER  = 8'h5F;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;

    // Keywords, first character in the most significant byte.
    localparam logic [31:0] KW_FUNC   = "func";
    localparam logic [47:0] KW_RETURN = "return";
    localparam logic [15:0] KW_IF     = "if";
    localparam logic [31:0] KW_ELSE   = "else";

    // Counter limits that do not follow a parameter.
    localparam logic [15:0] COL_MAX  = 16'hFFFF;
    localparam logic [15:0] CNT_MAX  = 16'hFFFF;
    localparam logic [62:0] VAL_MAX  = {63{1'b1}};
    localparam int          KW_DEPTH = 6;

    function automatic logic f_is_space(logic [7:0] c);
        return (c == CH_SPACE) || (c >= 8'd9 && c <= 8'd13);
    endfunction

    function automatic logic f_is_digit(logic [7:0] c);
        return (c >= "0") && (c <= "9");
    endfunction

    function automatic logic f_is_alpha(logic [7:0] c);
        return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
    endfunction

    function automatic logic f_is_word(logic [7:0] c);
        return f_is_alpha(c) || f_is_digit(c) || (c == CH_UNDER);
    endfunction

    // Kind of a byte that forms a token on its own; anything unknown is an error.
    function automatic t_kind f_single_kind(logic [7:0] c);
        t_kind k;
        case (c)
            CH_PLUS:   k = KIND_PLUS;
            CH_MINUS:  k = KIND_MINUS;
            CH_STAR:   k = KIND_STAR;
            CH_LPAREN: k = KIND_LPAREN;
            CH_RPAREN: k = KIND_RPAREN;
            CH_LBRACE: k = KIND_LBRACE;
            CH_RBRACE: k = KIND_RBRACE;
            CH_COMMA:  k = KIND_COMMA;
            CH_SEMI:   k = KIND_SEMI;
            default:   k = KIND_ERROR;
        endcase
        return k;
    endfunction

endpackage

### src/source_text_tokenizer_top.sv
// Streaming source tokenizer.
// Input channel: one source byte per beat on i_char_code (i_valid / o_stall);
// a zero byte ends the source, flushes any pending token and produces the
// end-of-source token, after which offset, line and column restart.
// Output channel: one token per beat (o_valid / i_stall) with kind, position,
// length, integer value, too-long flag and a last_of_run marker on the final
// token caused by a byte.
// Each byte is scanned in the cycle it is accepted and its tokens (zero to
// three) land in a four-entry result queue, registered when the byte is
// accepted. Throughput is one byte per cycle while bytes produce at most one
// token each; o_stall rises when the queue has fewer than three free entries,
// so bursts of two or three tokens from one byte, or a stalling receiver,
// pause the input until the queue drains. A stalled output beat holds its
// payload.
// Reset (synchronous, active low) empties the queue and returns the scanner
// to idle at offset 0, line 1, column 1.
module source_text_tokenizer_top #(
    parameter int OFFSET_BITS     = 24,
    parameter int LINE_BITS       = 20,
    parameter int MAX_LITERAL_LEN = 127
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_stall,
    input  logic [7:0]             i_char_code,
    output logic                   o_valid,
    input  logic                   i_stall,
    output logic [4:0]             o_token_kind,
    output logic [OFFSET_BITS-1:0] o_start_offset,
    output logic [15:0]            o_token_length,
    output logic [LINE_BITS-1:0]   o_start_line,
    output logic [15:0]            o_start_column,
    output logic [LINE_BITS-1:0]   o_end_line,
    output logic [15:0]            o_end_column,
    output logic [62:0]            o_int_value,
    output logic                   o_literal_too_long,
    output logic                   o_last_of_run
);

`include "assert_macros.svh"

    localparam logic [OFFSET_BITS-1:0] OFF_MAX  = {OFFSET_BITS{1'b1}};
    localparam logic [LINE_BITS-1:0]   LINE_MAX = {LINE_BITS{1'b1}};
    localparam logic [15:0]            LIT_MAX  = 16'(MAX_LITERAL_LEN);
    localparam int                     QUEUE_DEPTH = 4;

    // Position in the source.
    typedef struct packed {
        logic [OFFSET_BITS-1:0] pos;
        logic [LINE_BITS-1:0]   line;
        logic [15:0]            col;
    } t_cursor;

    // One result item.
    typedef struct packed {
        stt_pkg::t_kind         kind;
        logic [OFFSET_BITS-1:0] start_offset;
        logic [15:0]            length;
        logic [LINE_BITS-1:0]   start_line;
        logic [15:0]            start_column;
        logic [LINE_BITS-1:0]   end_line;
        logic [15:0]            end_column;
        logic [62:0]            int_value;
        logic                   too_long;
        logic                   last;
    } t_token;

    localparam t_cursor CUR_RESET = '{pos: '0, line: LINE_BITS'(1), col: 16'd1};

    function automatic t_cursor f_advance(t_cursor cur, logic [7:0] c);
        t_cursor nxt;
        nxt = cur;
        if (c == stt_pkg::CH_NL) begin
            if (cur.line != LINE_MAX) begin
                nxt.line = cur.line + 1'b1;
            end
            nxt.col = 16'd1;
        end else if (cur.col != stt_pkg::COL_MAX) begin
            nxt.col = cur.col + 1'b1;
        end
        if (cur.pos != OFF_MAX) begin
            nxt.pos = cur.pos + 1'b1;
        end
        return nxt;
    endfunction

    function automatic logic [15:0] f_count_up(logic [15:0] cnt);
        return (cnt != stt_pkg::CNT_MAX) ? cnt + 16'd1 : cnt;
    endfunction

    // Decimal accumulate with saturation; returns {saturated, value}.
    function automatic logic [63:0] f_add_digit(logic [62:0] acc, logic sat,
                                                logic [7:0] c);
        logic [66:0] prod;
        prod = {acc, 3'b000} + {2'b00, acc, 1'b0} + 67'(c - "0");
        if (sat || (prod > 67'(stt_pkg::VAL_MAX))) begin
            return {1'b1, stt_pkg::VAL_MAX};
        end
        return {1'b0, prod[62:0]};
    endfunction

    function automatic t_token f_token(stt_pkg::t_kind kind, logic [62:0] value,
                                       logic too_long, t_cursor start,
                                       logic [15:0] cnt, t_cursor cur);
        t_token t;
        t.kind         = kind;
        t.start_offset = start.pos;
        t.length       = cnt;
        t.start_line   = start.line;
        t.start_column = start.col;
        t.end_line     = cur.line;
        t.end_column   = cur.col;
        t.int_value    = value;
        t.too_long     = too_long;
        t.last         = 1'b0;
        return t;
    endfunction

    stt_pkg::t_mode r_mode, n_mode;
    t_cursor        r_cur, n_cur;
    t_cursor        r_tstart, n_tstart;
    logic [15:0]    r_cnt, n_cnt;
    logic [62:0]    r_acc, n_acc;
    logic           r_sat, n_sat;
    logic [7:0]     r_kw [stt_pkg::KW_DEPTH];

    logic           kw_we;
    logic [2:0]     kw_idx;
    logic [47:0]    kw_vec;
    logic [63:0]    digit_res;
    logic           run_idle;
    logic           too_long;
    stt_pkg::t_kind word_kind;
    t_token         toks [3];
    logic [1:0]     tok_count;
    logic [$bits(t_token)-1:0] push_data [3];
    logic [$bits(t_token)-1:0] head_data;
    t_token         head;
    logic           in_accept;
    logic           queue_room;
    logic           c_digit;

    assign in_accept = i_valid && !o_stall;
    assign o_stall   = !queue_room;
    assign c_digit   = stt_pkg::f_is_digit(i_char_code);

    // Keyword buffer, first byte in the top bits.
    assign kw_vec = {r_kw[0], r_kw[1], r_kw[2], r_kw[3], r_kw[4], r_kw[5]};

    // Keyword match on the finished identifier.
    always_comb begin
        word_kind = stt_pkg::KIND_IDENT;
        if (r_cnt == 16'd4 && kw_vec[47:16] == stt_pkg::KW_FUNC) begin
            word_kind = stt_pkg::KIND_FUNC;
        end else if (r_cnt == 16'd6 && kw_vec == stt_pkg::KW_RETURN) begin
            word_kind = stt_pkg::KIND_RETURN;
        end else if (r_cnt == 16'd2 && kw_vec[47:32] == stt_pkg::KW_IF) begin
            word_kind = stt_pkg::KIND_IF;
        end else if (r_cnt == 16'd4 && kw_vec[47:16] == stt_pkg::KW_ELSE) begin
            word_kind = stt_pkg::KIND_ELSE;
        end
    end

    assign too_long = (r_cnt >= LIT_MAX);

    // Scanner: finish the pending mode, then scan the byte from idle if needed.
    always_comb begin
        n_mode    = r_mode;
        n_cur     = r_cur;
        n_tstart  = r_tstart;
        n_cnt     = r_cnt;
        n_acc     = r_acc;
        n_sat     = r_sat;
        kw_we     = 1'b0;
        kw_idx    = '0;
        run_idle  = 1'b0;
        tok_count = 2'd0;
        digit_res = f_add_digit(r_acc, r_sat, i_char_code);
        for (int k = 0; k < 3; k++) begin
            toks[k] = '0;
        end

        case (r_mode)
            stt_pkg::MODE_SLASH: begin
                if (i_char_code == stt_pkg::CH_SLASH) begin
                    n_cur  = f_advance(f_advance(r_cur, stt_pkg::CH_SLASH),
                                       stt_pkg::CH_SLASH);
                    n_mode = stt_pkg::MODE_COMMENT;
                end else begin
                    n_tstart = r_cur;
                    n_cur    = f_advance(r_cur, stt_pkg::CH_SLASH);
                    n_cnt    = 16'd1;
                    toks[tok_count] = f_token(stt_pkg::KIND_SLASH, '0, 1'b0,
                                              n_tstart, n_cnt, n_cur);
                    tok_count = tok_count + 2'd1;
                    run_idle  = 1'b1;
                end
            end
            stt_pkg::MODE_COMMENT: begin
                if (i_char_code != stt_pkg::CH_NL && i_char_code != stt_pkg::CH_EOS) begin
                    n_cur = f_advance(r_cur, i_char_code);
                end else begin
                    run_idle = 1'b1;
                end
            end
            stt_pkg::MODE_INT: begin
                if (c_digit) begin
                    n_sat = digit_res[63];
                    n_acc = digit_res[62:0];
                    n_cur = f_advance(r_cur, i_char_code);
                    n_cnt = f_count_up(r_cnt);
                end else if (i_char_code == stt_pkg::CH_DOT) begin
                    n_mode = stt_pkg::MODE_INTDOT;
                end else begin
                    toks[tok_count] = f_token(stt_pkg::KIND_INT,
                                              too_long ? '0 : r_acc, too_long,
                                              r_tstart, r_cnt, r_cur);
                    tok_count = tok_count + 2'd1;
                    run_idle  = 1'b1;
                end
            end
            stt_pkg::MODE_INTDOT: begin
                if (c_digit) begin
                    n_cur  = f_advance(f_advance(r_cur, stt_pkg::CH_DOT), i_char_code);
                    n_cnt  = f_count_up(f_count_up(r_cnt));
                    n_mode = stt_pkg::MODE_FLOAT;
                end else begin
                    // Integer, then an error token for the dot.
                    toks[tok_count] = f_token(stt_pkg::KIND_INT,
                                              too_long ? '0 : r_acc, too_long,
                                              r_tstart, r_cnt, r_cur);
                    tok_count = tok_count + 2'd1;
                    n_tstart  = r_cur;
                    n_cur     = f_advance(r_cur, stt_pkg::CH_DOT);
                    n_cnt     = 16'd1;
                    toks[tok_count] = f_token(stt_pkg::KIND_ERROR, '0, 1'b0,
                                              n_tstart, n_cnt, n_cur);
                    tok_count = tok_count + 2'd1;
                    run_idle  = 1'b1;
                end
            end
            stt_pkg::MODE_FLOAT: begin
                if (c_digit) begin
                    n_cur = f_advance(r_cur, i_char_code);
                    n_cnt = f_count_up(r_cnt);
                end else begin
                    toks[tok_count] = f_token(stt_pkg::KIND_FLOAT, '0, too_long,
                                              r_tstart, r_cnt, r_cur);
                    tok_count = tok_count + 2'd1;
                    run_idle  = 1'b1;
                end
            end
            stt_pkg::MODE_IDENT: begin
                if (stt_pkg::f_is_word(i_char_code)) begin
                    if (r_cnt < 16'(stt_pkg::KW_DEPTH)) begin
                        kw_we  = 1'b1;
                        kw_idx = r_cnt[2:0];
                    end
                    n_cur = f_advance(r_cur, i_char_code);
                    n_cnt = f_count_up(r_cnt);
                end else begin
                    toks[tok_count] = f_token(word_kind, '0, 1'b0,
                                              r_tstart, r_cnt, r_cur);
                    tok_count = tok_count + 2'd1;
                    run_idle  = 1'b1;
                end
            end
            stt_pkg::MODE_EQ, stt_pkg::MODE_BANG: begin
                n_mode   = stt_pkg::MODE_IDLE;
                n_tstart = r_cur;
                if (i_char_code == stt_pkg::CH_EQ) begin
                    n_cur = f_advance(f_advance(r_cur, stt_pkg::CH_EQ), stt_pkg::CH_EQ);
                    n_cnt = 16'd2;
                    toks[tok_count] = f_token((r_mode == stt_pkg::MODE_EQ) ?
                                              stt_pkg::KIND_EQEQ : stt_pkg::KIND_BANGEQ,
                                              '0, 1'b0, n_tstart, n_cnt, n_cur);
                    tok_count = tok_count + 2'd1;
                end else begin
                    // Lone '=' is an assignment, a lone '!' is an error.
                    n_cur = f_advance(r_cur, stt_pkg::CH_EQ);
                    n_cnt = 16'd1;
                    toks[tok_count] = f_token((r_mode == stt_pkg::MODE_EQ) ?
                                              stt_pkg::KIND_ASSIGN : stt_pkg::KIND_ERROR,
                                              '0, 1'b0, n_tstart, n_cnt, n_cur);
                    tok_count = tok_count + 2'd1;
                    run_idle  = 1'b1;
                end
            end
            default: begin
                run_idle = 1'b1;
            end
        endcase

        // Scan the byte as the first byte of something new.
        if (run_idle) begin
            n_mode = stt_pkg::MODE_IDLE;
            if (stt_pkg::f_is_space(i_char_code)) begin
                n_cur = f_advance(n_cur, i_char_code);
            end else if (i_char_code == stt_pkg::CH_EOS) begin
                n_tstart = n_cur;
                n_cnt    = 16'd0;
                toks[tok_count] = f_token(stt_pkg::KIND_EOF, '0, 1'b0,
                                          n_tstart, n_cnt, n_cur);
                tok_count = tok_count + 2'd1;
                n_cur     = CUR_RESET;
            end else if (i_char_code == stt_pkg::CH_SLASH) begin
                n_mode = stt_pkg::MODE_SLASH;
            end else if (i_char_code == stt_pkg::CH_EQ) begin
                n_mode = stt_pkg::MODE_EQ;
            end else if (i_char_code == stt_pkg::CH_BANG) begin
                n_mode = stt_pkg::MODE_BANG;
            end else if (c_digit) begin
                n_tstart = n_cur;
                n_acc    = 63'(i_char_code - "0");
                n_sat    = 1'b0;
                n_cur    = f_advance(n_cur, i_char_code);
                n_cnt    = 16'd1;
                n_mode   = stt_pkg::MODE_INT;
            end else if (stt_pkg::f_is_alpha(i_char_code) ||
                         i_char_code == stt_pkg::CH_UNDER) begin
                n_tstart = n_cur;
                kw_we    = 1'b1;
                kw_idx   = 3'd0;
                n_cur    = f_advance(n_cur, i_char_code);
                n_cnt    = 16'd1;
                n_mode   = stt_pkg::MODE_IDENT;
            end else begin
                n_tstart = n_cur;
                n_cur    = f_advance(n_cur, i_char_code);
                n_cnt    = 16'd1;
                toks[tok_count] = f_token(stt_pkg::f_single_kind(i_char_code), '0, 1'b0,
                                          n_tstart, n_cnt, n_cur);
                tok_count = tok_count + 2'd1;
            end
        end

        // Mark the final token caused by this byte.
        for (int k = 0; k < 3; k++) begin
            toks[k].last = (2'(k) == tok_count - 2'd1);
        end
    end

    // Scanner state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= stt_pkg::MODE_IDLE;
            r_cur    <= CUR_RESET;
            r_tstart <= CUR_RESET;
            r_cnt    <= '0;
            r_acc    <= '0;
            r_sat    <= 1'b0;
        end else if (in_accept) begin
            r_mode   <= n_mode;
            r_cur    <= n_cur;
            r_tstart <= n_tstart;
            r_cnt    <= n_cnt;
            r_acc    <= n_acc;
            r_sat    <= n_sat;
        end
    end

    // Keyword prefix bytes; only entries written for the current word are read.
    always_ff @(posedge i_clk) begin
        if (in_accept && kw_we) begin
            r_kw[kw_idx] <= i_char_code;
        end
    end

    // Result queue.
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            push_data[k] = toks[k];
        end
    end

    stt_fifo #(
        .WIDTH ($bits(t_token)),
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_count (in_accept ? tok_count : 2'd0),
        .i_push_data  (push_data),
        .i_pop        (!i_stall),
        .o_head       (head_data),
        .o_valid      (o_valid),
        .o_room       (queue_room)
    );

    // Output fields.
    assign head               = t_token'(head_data);
    assign o_token_kind       = head.kind;
    assign o_start_offset     = head.start_offset;
    assign o_token_length     = head.length;
    assign o_start_line       = head.start_line;
    assign o_start_column     = head.start_column;
    assign o_end_line         = head.end_line;
    assign o_end_column       = head.end_column;
    assign o_int_value        = head.int_value;
    assign o_literal_too_long = head.too_long;
    assign o_last_of_run      = head.last;

    // End of source returns the scanner to idle at the origin.
    `ASSERT_NEXT(a_eos_restart, i_clk, i_rst_n,
        in_accept && (i_char_code == stt_pkg::CH_EOS),
        (r_mode == stt_pkg::MODE_IDLE) && (r_cur == CUR_RESET) && o_valid,
        "end of source did not restart the scanner")

    // Two-byte comparison tokens always have length two.
    `ASSERT_IMPLY(a_cmp_len, i_clk, i_rst_n,
        o_valid && ((o_token_kind == stt_pkg::KIND_EQEQ) ||
                    (o_token_kind == stt_pkg::KIND_BANGEQ)),
        o_token_length == 16'd2,
        "comparison token with wrong length")

    // The too-long flag belongs to numeric literals only.
    `ASSERT_IMPLY(a_too_long_kind, i_clk, i_rst_n,
        o_valid && o_literal_too_long,
        (o_token_kind == stt_pkg::KIND_INT) || (o_token_kind == stt_pkg::KIND_FLOAT),
        "too-long flag on a non-numeric token")

    // A saturated accumulator holds the maximum value.
    `ASSERT_IMPLY(a_sat_value, i_clk, i_rst_n,
        r_sat,
        r_acc == stt_pkg::VAL_MAX,
        "saturated accumulator below maximum")

endmodule

### src/stt_fifo.sv
// Result queue: takes up to three entries per cycle, hands out one per cycle while popped and not empty.
// DEPTH must be a power of two and at least four.
module stt_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [1:0]       i_push_count,
    input  logic [WIDTH-1:0] i_push_data [3],
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_head,
    output logic             o_valid,
    output logic             o_room
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [CNT_W-1:0] ROOM_LIMIT = CNT_W'(DEPTH - 3);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             pop_en;

    assign pop_en  = i_pop && (r_count != '0);
    assign o_valid = (r_count != '0);
    assign o_head  = r_mem[r_rd_ptr];
    // Room for a full burst of three entries, regardless of a pop this cycle.
    assign o_room  = (r_count <= ROOM_LIMIT);

    // Storage writes.
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 3; k++) begin
            if (k < int'(i_push_count)) begin
                r_mem[r_wr_ptr + PTR_W'(k)] <= i_push_data[k];
            end
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= r_wr_ptr + PTR_W'(i_push_count);
            if (pop_en) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            r_count <= r_count + CNT_W'(i_push_count) - CNT_W'(pop_en);
        end
    end

endmodule

### verif/tb_source_text_tokenizer_top.sv
`timescale 1ns / 1ps

module tb_source_text_tokenizer_top;

    import stt_pkg::*;

    localparam logic [23:0] POS_TOP       = 24'hFFFFFF;
    localparam logic [19:0] LINE_TOP      = 20'hFFFFF;
    localparam int          LITERAL_LIMIT = 127;
    localparam int          DIR_ROWS      = 25;
    localparam int          PHASE_BYTES   = 110;

    // One token as it appears on the result port.
    typedef struct {
        t_kind       kind;
        logic [23:0] start_offset;
        logic [15:0] length;
        logic [19:0] start_line;
        logic [15:0] start_column;
        logic [19:0] end_line;
        logic [15:0] end_column;
        logic [62:0] int_value;
        logic        too_long;
        logic        last_of_run;
    } tok_t;

    // One directed source byte, with its token written out where it is obvious.
    typedef struct {
        logic [7:0] ch;
        bit         typed;
        tok_t       tok;
    } byte_row_t;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic [7:0]  i_char_code = 8'h00;
    logic        i_stall = 1'b0;
    logic        o_stall;
    logic        o_valid;
    logic [4:0]  o_token_kind;
    logic [23:0] o_start_offset;
    logic [15:0] o_token_length;
    logic [19:0] o_start_line;
    logic [15:0] o_start_column;
    logic [19:0] o_end_line;
    logic [15:0] o_end_column;
    logic [62:0] o_int_value;
    logic        o_literal_too_long;
    logic        o_last_of_run;

    // Scanner state of the token predictor.
    t_mode       lx_mode;
    logic [23:0] lx_pos;
    logic [23:0] lx_tok_off;
    logic [19:0] lx_line;
    logic [19:0] lx_tok_line;
    logic [15:0] lx_col;
    logic [15:0] lx_tok_col;
    logic [15:0] lx_tok_len;
    logic [62:0] lx_acc;
    logic        lx_sat;
    logic [7:0]  lx_word [KW_DEPTH];

    tok_t        step_tokens[$];
    tok_t        pending_tokens[$];
    logic [7:0]  src_text[$];
    byte_row_t   dir_rows[DIR_ROWS];

    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;
    int          mismatches = 0;
    int          bytes_fed = 0;
    int          tokens_checked = 0;

    string       ID_HEAD = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_";
    string       ID_TAIL = "abcdefgiflnrstuxyzEFQ_0123456789";
    string       OPERATORS = "+-*/(){},;";
    string       KEYWORDS[4] = '{"func", "return", "if", "else"};
    string       NEAR_KEYWORDS[8] = '{"fun", "funcs", "retur", "returns", "i", "iff",
                                      "els", "elseif"};
    string       EQ_FORMS[4] = '{"=", "==", "!=", "!"};

    source_text_tokenizer_top dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_valid            (i_valid),
        .o_stall            (o_stall),
        .i_char_code        (i_char_code),
        .o_valid            (o_valid),
        .i_stall            (i_stall),
        .o_token_kind       (o_token_kind),
        .o_start_offset     (o_start_offset),
        .o_token_length     (o_token_length),
        .o_start_line       (o_start_line),
        .o_start_column     (o_start_column),
        .o_end_line         (o_end_line),
        .o_end_column       (o_end_column),
        .o_int_value        (o_int_value),
        .o_literal_too_long (o_literal_too_long),
        .o_last_of_run      (o_last_of_run)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Character classes, kept separate from the design's own helpers.
    function automatic logic is_blank(logic [7:0] c);
        return (c == CH_SPACE) || (c >= 8'd9 && c <= 8'd13);
    endfunction

    function automatic logic is_num(logic [7:0] c);
        return (c >= "0") && (c <= "9");
    endfunction

    function automatic logic is_letter(logic [7:0] c);
        return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
    endfunction

    function automatic void reset_lexer();
        lx_mode     = MODE_IDLE;
        lx_pos      = '0;
        lx_line     = 20'd1;
        lx_col      = 16'd1;
        lx_tok_off  = '0;
        lx_tok_line = 20'd1;
        lx_tok_col  = 16'd1;
        lx_tok_len  = '0;
        lx_acc      = '0;
        lx_sat      = 1'b0;
        foreach (lx_word[i]) lx_word[i] = 8'h00;
    endfunction

    // Move the position counters past one byte; every counter saturates.
    function automatic void step_pos(logic [7:0] c);
        if (c == CH_NL) begin
            if (lx_line != LINE_TOP) lx_line++;
            lx_col = 16'd1;
        end else if (lx_col != COL_MAX) begin
            lx_col++;
        end
        if (lx_pos != POS_TOP) lx_pos++;
    endfunction

    function automatic void mark_token();
        lx_tok_off  = lx_pos;
        lx_tok_line = lx_line;
        lx_tok_col  = lx_col;
        lx_tok_len  = '0;
    endfunction

    function automatic void bump_len();
        if (lx_tok_len != CNT_MAX) lx_tok_len++;
    endfunction

    function automatic void push_token(t_kind k, logic [62:0] val, logic too_long);
        tok_t t;
        if (step_tokens.size() >= 3) return;
        t.kind         = k;
        t.start_offset = lx_tok_off;
        t.length       = lx_tok_len;
        t.start_line   = lx_tok_line;
        t.start_column = lx_tok_col;
        t.end_line     = lx_line;
        t.end_column   = lx_col;
        t.int_value    = val;
        t.too_long     = too_long;
        t.last_of_run  = 1'b0;
        step_tokens.push_back(t);
    endfunction

    function automatic void single_token(t_kind k, logic [7:0] c);
        mark_token();
        step_pos(c);
        bump_len();
        push_token(k, '0, 1'b0);
    endfunction

    function automatic void number_token(logic is_float);
        logic too_long;
        too_long = (lx_tok_len >= LITERAL_LIMIT);
        push_token(is_float ? KIND_FLOAT : KIND_INT,
                   (is_float || too_long) ? 63'd0 : lx_acc, too_long);
    endfunction

    // Identifiers become keywords only on an exact match of length and bytes.
    function automatic void word_token();
        t_kind k;
        k = KIND_IDENT;
        if (lx_tok_len == 4 && {lx_word[0], lx_word[1], lx_word[2], lx_word[3]} == KW_FUNC)
            k = KIND_FUNC;
        else if (lx_tok_len == 6 && {lx_word[0], lx_word[1], lx_word[2], lx_word[3],
                                     lx_word[4], lx_word[5]} == KW_RETURN)
            k = KIND_RETURN;
        else if (lx_tok_len == 2 && {lx_word[0], lx_word[1]} == KW_IF)
            k = KIND_IF;
        else if (lx_tok_len == 4 && {lx_word[0], lx_word[1], lx_word[2], lx_word[3]} == KW_ELSE)
            k = KIND_ELSE;
        push_token(k, '0, 1'b0);
    endfunction

    // Decimal accumulation that sticks at the largest signed 64-bit value.
    function automatic void add_digit(logic [7:0] c);
        logic [63:0] d;
        logic [63:0] room;
        d    = 64'(c) - 64'("0");
        room = ({1'b0, VAL_MAX} - d) / 64'd10;
        if (lx_sat || {1'b0, lx_acc} > room) begin
            lx_acc = VAL_MAX;
            lx_sat = 1'b1;
        end else begin
            lx_acc = lx_acc * 63'd10 + d[62:0];
        end
    endfunction

    // A byte seen with no token in progress.
    function automatic void lex_fresh(logic [7:0] c);
        t_kind k;
        if (is_blank(c)) begin
            step_pos(c);
            return;
        end
        if (c == CH_EOS) begin
            mark_token();
            push_token(KIND_EOF, '0, 1'b0);
            lx_mode = MODE_IDLE;
            lx_pos  = '0;
            lx_line = 20'd1;
            lx_col  = 16'd1;
            return;
        end
        if (c == CH_SLASH) begin
            lx_mode = MODE_SLASH;
            return;
        end
        if (c == CH_EQ) begin
            lx_mode = MODE_EQ;
            return;
        end
        if (c == CH_BANG) begin
            lx_mode = MODE_BANG;
            return;
        end
        if (is_num(c)) begin
            mark_token();
            lx_acc = '0;
            lx_sat = 1'b0;
            add_digit(c);
            step_pos(c);
            bump_len();
            lx_mode = MODE_INT;
            return;
        end
        if (is_letter(c) || c == CH_UNDER) begin
            mark_token();
            lx_word[0] = c;
            step_pos(c);
            bump_len();
            lx_mode = MODE_IDENT;
            return;
        end
        case (c)
            CH_PLUS:   k = KIND_PLUS;
            CH_MINUS:  k = KIND_MINUS;
            CH_STAR:   k = KIND_STAR;
            CH_LPAREN: k = KIND_LPAREN;
            CH_RPAREN: k = KIND_RPAREN;
            CH_LBRACE: k = KIND_LBRACE;
            CH_RBRACE: k = KIND_RBRACE;
            CH_COMMA:  k = KIND_COMMA;
            CH_SEMI:   k = KIND_SEMI;
            default:   k = KIND_ERROR;
        endcase
        single_token(k, c);
    endfunction

    // Tokens caused by one accepted byte, left in step_tokens.
    function automatic void tokenize_byte(logic [7:0] c);
        logic eq;
        step_tokens.delete();
        case (lx_mode)
            MODE_SLASH: begin
                if (c == CH_SLASH) begin
                    step_pos(CH_SLASH);
                    step_pos(CH_SLASH);
                    lx_mode = MODE_COMMENT;
                end else begin
                    lx_mode = MODE_IDLE;
                    single_token(KIND_SLASH, CH_SLASH);
                    lex_fresh(c);
                end
            end
            MODE_COMMENT: begin
                if (c != CH_NL && c != CH_EOS) begin
                    step_pos(c);
                end else begin
                    lx_mode = MODE_IDLE;
                    lex_fresh(c);
                end
            end
            MODE_INT: begin
                if (is_num(c)) begin
                    add_digit(c);
                    step_pos(c);
                    bump_len();
                end else if (c == CH_DOT) begin
                    lx_mode = MODE_INTDOT;
                end else begin
                    lx_mode = MODE_IDLE;
                    number_token(1'b0);
                    lex_fresh(c);
                end
            end
            MODE_INTDOT: begin
                if (is_num(c)) begin
                    step_pos(CH_DOT);
                    bump_len();
                    step_pos(c);
                    bump_len();
                    lx_mode = MODE_FLOAT;
                end else begin
                    lx_mode = MODE_IDLE;
                    number_token(1'b0);
                    single_token(KIND_ERROR, CH_DOT);
                    lex_fresh(c);
                end
            end
            MODE_FLOAT: begin
                if (is_num(c)) begin
                    step_pos(c);
                    bump_len();
                end else begin
                    lx_mode = MODE_IDLE;
                    number_token(1'b1);
                    lex_fresh(c);
                end
            end
            MODE_IDENT: begin
                if (is_letter(c) || is_num(c) || c == CH_UNDER) begin
                    if (lx_tok_len < KW_DEPTH) lx_word[lx_tok_len] = c;
                    step_pos(c);
                    bump_len();
                end else begin
                    lx_mode = MODE_IDLE;
                    word_token();
                    lex_fresh(c);
                end
            end
            MODE_EQ, MODE_BANG: begin
                eq = (lx_mode == MODE_EQ);
                lx_mode = MODE_IDLE;
                if (c == CH_EQ) begin
                    mark_token();
                    step_pos(CH_EQ);
                    step_pos(CH_EQ);
                    lx_tok_len = 16'd2;
                    push_token(eq ? KIND_EQEQ : KIND_BANGEQ, '0, 1'b0);
                end else begin
                    single_token(eq ? KIND_ASSIGN : KIND_ERROR, eq ? CH_EQ : CH_BANG);
                    lex_fresh(c);
                end
            end
            default: begin
                lx_mode = MODE_IDLE;
                lex_fresh(c);
            end
        endcase
        if (step_tokens.size() != 0) step_tokens[step_tokens.size() - 1].last_of_run = 1'b1;
    endfunction

    function automatic byte_row_t free_row(logic [7:0] c);
        byte_row_t r;
        r.ch    = c;
        r.typed = 1'b0;
        return r;
    endfunction

    // Single token on line 1 with no value.
    function automatic byte_row_t known_row(logic [7:0] c, t_kind k, int off, int len,
                                            int sc, int ec);
        byte_row_t r;
        r.ch                   = c;
        r.typed                = 1'b1;
        r.tok.kind             = k;
        r.tok.start_offset     = 24'(off);
        r.tok.length           = 16'(len);
        r.tok.start_line       = 20'd1;
        r.tok.start_column     = 16'(sc);
        r.tok.end_line         = 20'd1;
        r.tok.end_column       = 16'(ec);
        r.tok.int_value        = '0;
        r.tok.too_long         = 1'b0;
        r.tok.last_of_run      = 1'b1;
        return r;
    endfunction

    function automatic void add_word(string s);
        for (int i = 0; i < s.len(); i++) src_text.push_back(s[i]);
    endfunction

    function automatic void add_digits(int n);
        repeat (n) src_text.push_back(8'("0") + 8'($urandom_range(0, 9)));
    endfunction

    function automatic logic [7:0] blank_byte();
        return ($urandom_range(0, 1) != 0) ? CH_SPACE : 8'($urandom_range(9, 13));
    endfunction

    // Mostly well-formed token text with random content, some noise and stray bytes.
    function automatic void add_fragment();
        int n;
        case ($urandom_range(0, 19))
            0, 1, 2, 3: begin
                src_text.push_back(ID_HEAD[$urandom_range(0, ID_HEAD.len() - 1)]);
                n = $urandom_range(0, 6);
                repeat (n) src_text.push_back(ID_TAIL[$urandom_range(0, ID_TAIL.len() - 1)]);
            end
            4:       add_word(KEYWORDS[$urandom_range(0, 3)]);
            5:       add_word(NEAR_KEYWORDS[$urandom_range(0, 7)]);
            6, 7:    add_digits(($urandom_range(0, 9) == 0) ? $urandom_range(18, 21)
                                                            : $urandom_range(1, 4));
            8: begin
                add_digits($urandom_range(1, 3));
                src_text.push_back(CH_DOT);
                add_digits($urandom_range(1, 3));
            end
            9: begin
                add_digits($urandom_range(1, 2));
                src_text.push_back(CH_DOT);
            end
            10:      src_text.push_back(CH_DOT);
            11, 12:  src_text.push_back(OPERATORS[$urandom_range(0, OPERATORS.len() - 1)]);
            13:      add_word(EQ_FORMS[$urandom_range(0, 3)]);
            14: begin
                add_word("//");
                n = $urandom_range(0, 6);
                repeat (n) src_text.push_back(8'($urandom_range(1, 255)));
                src_text.push_back(($urandom_range(0, 7) == 0) ? CH_EOS : CH_NL);
            end
            15, 16:  src_text.push_back(blank_byte());
            17, 19:  src_text.push_back(8'($urandom_range(0, 255)));
            default: src_text.push_back(CH_EOS);
        endcase
        if ($urandom_range(0, 2) == 0) src_text.push_back(blank_byte());
    endfunction

    // Present one byte and hold it until the block takes the beat.
    task automatic feed_byte(input logic [7:0] c);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid     <= 1'b1;
        i_char_code <= c;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        bytes_fed++;
    endtask

    task automatic feed_text();
        logic [7:0] c;
        while (src_text.size() != 0) begin
            c = src_text.pop_front();
            feed_byte(c);
            tokenize_byte(c);
            foreach (step_tokens[j]) pending_tokens.push_back(step_tokens[j]);
        end
    endtask

    // Result side: random stall, and each accepted beat checked against the oldest token.
    always @(posedge i_clk) begin
        tok_t want;
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall) begin
                tokens_checked++;
                if (pending_tokens.size() == 0) begin
                    $error("token with nothing pending: kind %0d offset %0d",
                           o_token_kind, o_start_offset);
                    mismatches++;
                end else begin
                    want = pending_tokens.pop_front();
                    if (o_token_kind !== want.kind) begin
                        $error("token_kind: expected %0d, got %0d", want.kind, o_token_kind);
                        mismatches++;
                    end
                    if (o_start_offset !== want.start_offset) begin
                        $error("start_offset: expected %0d, got %0d",
                               want.start_offset, o_start_offset);
                        mismatches++;
                    end
                    if (o_token_length !== want.length) begin
                        $error("token_length: expected %0d, got %0d",
                               want.length, o_token_length);
                        mismatches++;
                    end
                    if (o_start_line !== want.start_line) begin
                        $error("start_line: expected %0d, got %0d",
                               want.start_line, o_start_line);
                        mismatches++;
                    end
                    if (o_start_column !== want.start_column) begin
                        $error("start_column: expected %0d, got %0d",
                               want.start_column, o_start_column);
                        mismatches++;
                    end
                    if (o_end_line !== want.end_line) begin
                        $error("end_line: expected %0d, got %0d", want.end_line, o_end_line);
                        mismatches++;
                    end
                    if (o_end_column !== want.end_column) begin
                        $error("end_column: expected %0d, got %0d",
                               want.end_column, o_end_column);
                        mismatches++;
                    end
                    if (o_int_value !== want.int_value) begin
                        $error("int_value: expected %0d, got %0d",
                               want.int_value, o_int_value);
                        mismatches++;
                    end
                    if (o_literal_too_long !== want.too_long) begin
                        $error("literal_too_long: expected %0d, got %0d",
                               want.too_long, o_literal_too_long);
                        mismatches++;
                    end
                    if (o_last_of_run !== want.last_of_run) begin
                        $error("last_of_run: expected %0d, got %0d",
                               want.last_of_run, o_last_of_run);
                        mismatches++;
                    end
                end
            end
            i_stall <= ($urandom_range(0, 99) < recv_stall_pct);
        end
    end

    // Stimulus: directed bytes, counter and literal extremes, then four pacing phases.
    initial begin
        int send_pct[4];
        int recv_pct[4];
        send_pct = '{0, 76, 0, 34};
        recv_pct = '{0, 0, 76, 34};
        dir_rows = '{
            known_row(CH_EOS, KIND_EOF, 0, 0, 1, 1),
            known_row(CH_PLUS, KIND_PLUS, 0, 1, 1, 2),
            known_row("#", KIND_ERROR, 1, 1, 2, 3),
            known_row(8'hFF, KIND_ERROR, 2, 1, 3, 4),
            free_row(CH_BANG),
            free_row(CH_UNDER),
            free_row(CH_EQ),
            free_row(CH_EQ),
            free_row(CH_BANG),
            free_row(CH_EQ),
            free_row("1"),
            free_row(CH_DOT),
            free_row(CH_SEMI),
            free_row(CH_SLASH),
            free_row(CH_SLASH),
            free_row("z"),
            free_row(CH_NL),
            free_row("9"),
            free_row(CH_DOT),
            free_row("5"),
            free_row(CH_EQ),
            free_row(CH_SLASH),
            free_row("i"),
            free_row("f"),
            free_row(CH_EOS)
        };
        reset_lexer();
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed bytes: lone bang, dot after an integer, comment, float, keyword, flush.
        foreach (dir_rows[r]) begin
            feed_byte(dir_rows[r].ch);
            tokenize_byte(dir_rows[r].ch);
            if (dir_rows[r].typed) pending_tokens.push_back(dir_rows[r].tok);
            else foreach (step_tokens[j]) pending_tokens.push_back(step_tokens[j]);
        end

        // Integer saturation, the too-long boundary, and column and length saturation.
        add_word("9223372036854775807 9223372036854775808;99999999999999999999999\n");
        add_digits(LITERAL_LIMIT - 1);
        add_word(" ");
        add_digits(LITERAL_LIMIT);
        add_word(" 1.");
        add_digits(LITERAL_LIMIT - 2);
        add_word("+\n");
        repeat (65540) src_text.push_back("q");
        src_text.push_back(CH_EOS);
        feed_text();

        for (int ph = 0; ph < 4; ph++) begin
            send_idle_pct  = send_pct[ph];
            recv_stall_pct = recv_pct[ph];
            while (src_text.size() < PHASE_BYTES) add_fragment();
            src_text.push_back(CH_EOS);
            feed_text();
        end
        i_valid <= 1'b0;

        while (pending_tokens.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        $display("Fed %0d source bytes: directed, literal and counter extremes, four pacing",
                 bytes_fed);
        $display("phases of random token text; %0d tokens checked.", tokens_checked);
        if (mismatches == 0) begin
            $display("tb_source_text_tokenizer_top OK");
        end else begin
            $display("tb_source_text_tokenizer_top NOT OK");
        end
        $finish;
    end

    // Watchdog far beyond the slowest legal run.
    initial begin
        #20_000_000;
        $display("tb_source_text_tokenizer_top NOT OK");
        $finish;
    end

endmodule
